[sv/bf16dp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BF16 dot product package
// Shared types, constants and helper functions for the BF16 dot product lanes.
// ----------------------------------------------------------------------------
package bf16dp_pkg;

  localparam logic [31:0] F32_DEF_NAN = 32'hFFC0_0000;
  localparam logic [31:0] F32_QUIET   = 32'h0040_0000;
  localparam logic [15:0] BF16_QUIET  = 16'h0040;
  localparam logic [31:0] RND_BIAS    = 32'h0000_7FFF;
  localparam int          HALF_SHIFT  = 16;
  localparam int          FRAME_W     = 52;
  localparam int          EXP_W       = 11;
  localparam int          QDEPTH      = 4;
  localparam int          QPTR_W      = 2;
  localparam int          QCNT_W      = 3;

  typedef enum logic [2:0] {
    PK_FINITE,
    PK_ZERO,
    PK_INF,
    PK_NAN,
    PK_INVALID
  } prod_kind_t;

  typedef struct packed {
    prod_kind_t              kind;
    logic                    sign;
    logic signed [EXP_W-1:0] top;
    logic [15:0]             sig;
    logic [15:0]             nan16;
  } prod_t;

  typedef struct packed {
    logic step;
    logic clear;
  } lane_ctrl_t;

  function automatic logic [5:0] lzc52(input logic [FRAME_W-1:0] x);
    logic [5:0] n;
    n = 6'd52;
    for (int i = 0; i < FRAME_W; i++) begin
      if (x[i]) n = 6'(FRAME_W - 1 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc16(input logic [15:0] x);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) n = 5'(15 - i);
    end
    return n;
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] bits);
    logic [31:0] t;
    t = bits + RND_BIAS + {31'b0, bits[HALF_SHIFT]};
    return t[31:HALF_SHIFT];
  endfunction

endpackage

[sv/bf16dp_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BF16 dot product channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface bf16dp_in_if #(parameter int LANES = 8);
  logic                   valid;
  logic                   ready;
  logic [15:0]            act_value;
  logic [LANES-1:0][15:0] wgt_lane;
  logic                   final_term;

  modport source (output valid, act_value, wgt_lane, final_term, input ready);
  modport sink (input valid, act_value, wgt_lane, final_term, output ready);
endinterface

interface bf16dp_out_if #(parameter int LANES = 8);
  logic                   valid;
  logic                   ready;
  logic [LANES-1:0][15:0] sum_lane;

  modport source (output valid, sum_lane, input ready);
  modport sink (input valid, sum_lane, output ready);
endinterface

[sv/bf16dp_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BF16 dot product lane
// Decodes one BF16 product into a register, then fuses it into the FP32
// accumulator with a single round to nearest even.
// ----------------------------------------------------------------------------
module bf16dp_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [15:0]            act,
  input  logic [15:0]            wgt,
  input  bf16dp_pkg::lane_ctrl_t ctrl,
  output logic [31:0]            acc_next
);
  import bf16dp_pkg::*;

  prod_t prod;
  prod_t prod_next;
  logic [31:0] acc;

  logic [7:0] af, wf;
  logic [6:0] am, wm;
  logic a_nan, a_inf, a_zero, w_nan, w_inf, w_zero;
  logic [15:0] praw;
  logic [4:0] plz;
  logic signed [EXP_W-1:0] ea, eb;

  logic c_nan, c_inf, c_zero, sc;
  logic [23:0] asig;
  logic signed [EXP_W-1:0] at, big_t, lim, eh, expf;
  logic [EXP_W-1:0] da, db;
  logic [FRAME_W-1:0] a_al, b_al, mag;
  logic [FRAME_W:0] diff;
  logic sgn, rnd;
  logic [5:0] lz, sh;
  logic [FRAME_W-1:0] nrm;
  logic [30:0] packed_val;
  logic [31:0] gen_res;

  function automatic logic [FRAME_W-1:0] shr_sticky(input logic [FRAME_W-1:0] x,
                                                    input logic [EXP_W-1:0] d);
    logic [FRAME_W-1:0] mask;
    logic [FRAME_W-1:0] r;
    mask = ~({FRAME_W{1'b1}} << d[5:0]);
    if (d >= EXP_W'(FRAME_W)) begin
      r = {{(FRAME_W-1){1'b0}}, |x};
    end else begin
      r = (x >> d[5:0]) | {{(FRAME_W-1){1'b0}}, |(x & mask)};
    end
    return r;
  endfunction

  always_comb begin
    af = act[14:7];
    am = act[6:0];
    wf = wgt[14:7];
    wm = wgt[6:0];
    a_nan  = (af == 8'hFF) && (am != 7'd0);
    a_inf  = (af == 8'hFF) && (am == 7'd0);
    a_zero = (af == 8'd0) && (am == 7'd0);
    w_nan  = (wf == 8'hFF) && (wm == 7'd0) ? 1'b0 : (wf == 8'hFF);
    w_inf  = (wf == 8'hFF) && (wm == 7'd0);
    w_zero = (wf == 8'd0) && (wm == 7'd0);
    ea = (af == 8'd0) ? -EXP_W'(133) : $signed({3'b0, af}) - EXP_W'(134);
    eb = (wf == 8'd0) ? -EXP_W'(133) : $signed({3'b0, wf}) - EXP_W'(134);
    praw = {8'b0, (af != 8'd0), am} * {8'b0, (wf != 8'd0), wm};
    plz = lzc16(praw);
    prod_next.sign  = act[15] ^ wgt[15];
    prod_next.sig   = praw << plz[3:0];
    prod_next.top   = ea + eb + EXP_W'(15) - $signed({6'b0, plz});
    prod_next.nan16 = 16'd0;
    if (a_nan) begin
      prod_next.kind  = PK_NAN;
      prod_next.nan16 = act | BF16_QUIET;
    end else if (w_nan) begin
      prod_next.kind  = PK_NAN;
      prod_next.nan16 = wgt | BF16_QUIET;
    end else if (a_inf || w_inf) begin
      prod_next.kind = (a_zero || w_zero) ? PK_INVALID : PK_INF;
    end else if (a_zero || w_zero) begin
      prod_next.kind = PK_ZERO;
    end else begin
      prod_next.kind = PK_FINITE;
    end
  end

  always_comb begin
    c_nan  = (acc[30:23] == 8'hFF) && (acc[22:0] != 23'd0);
    c_inf  = (acc[30:23] == 8'hFF) && (acc[22:0] == 23'd0);
    c_zero = (acc[30:0] == 31'd0);
    sc     = acc[31];

    asig  = {(acc[30:23] != 8'd0), acc[22:0]};
    at    = (acc[30:23] == 8'd0) ? -EXP_W'(126) : $signed({3'b0, acc[30:23]}) - EXP_W'(127);
    big_t = (at > prod.top) ? at : prod.top;
    da    = EXP_W'(big_t - at);
    db    = EXP_W'(big_t - prod.top);
    a_al  = shr_sticky({1'b0, asig, 27'b0}, da);
    b_al  = shr_sticky({1'b0, prod.sig, 35'b0}, db);
    diff  = {1'b0, a_al} - {1'b0, b_al};
    if (prod.sign == sc) begin
      mag = a_al + b_al;
      sgn = sc;
    end else if (diff[FRAME_W]) begin
      mag = b_al - a_al;
      sgn = prod.sign;
    end else begin
      mag = diff[FRAME_W-1:0];
      sgn = sc;
    end
    lz  = lzc52(mag);
    lim = big_t + EXP_W'(127);
    sh  = ($signed({5'b0, lz}) < lim) ? lz : lim[5:0];
    nrm = mag << sh;
    eh  = big_t + EXP_W'(1) - $signed({5'b0, sh});
    expf = nrm[FRAME_W-1] ? eh + EXP_W'(127) : EXP_W'(0);
    rnd = nrm[27] & ((|nrm[26:0]) | nrm[28]);
    packed_val = {expf[7:0], nrm[50:28]} + {30'b0, rnd};
    if (mag == '0) begin
      gen_res = 32'd0;
    end else if (nrm[FRAME_W-1] && (expf >= EXP_W'(255))) begin
      gen_res = {sgn, 8'hFF, 23'd0};
    end else begin
      gen_res = {sgn, packed_val};
    end

    if (prod.kind == PK_NAN) begin
      acc_next = {prod.nan16, 16'd0};
    end else if (c_nan) begin
      acc_next = acc | F32_QUIET;
    end else if (prod.kind == PK_INVALID) begin
      acc_next = F32_DEF_NAN;
    end else if (prod.kind == PK_INF) begin
      acc_next = (c_inf && (sc != prod.sign)) ? F32_DEF_NAN : {prod.sign, 8'hFF, 23'd0};
    end else if (c_inf) begin
      acc_next = acc;
    end else if (prod.kind == PK_ZERO) begin
      acc_next = c_zero ? {prod.sign & sc, 31'd0} : acc;
    end else begin
      acc_next = gen_res;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
    end else if (ctrl.step) begin
      acc <= ctrl.clear ? 32'd0 : acc_next;
    end
  end

endmodule

[sv/bf16dp_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BF16 dot product merge stage
// Captures the lane sums of a finished item, rounds them to BF16 and queues
// the result item for the output channel.
// ----------------------------------------------------------------------------
module bf16dp_merge #(
  parameter int LANES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic [LANES-1:0][31:0]              lane_res,
  output logic [bf16dp_pkg::QCNT_W-1:0]       occupancy,
  bf16dp_out_if.source                        out_ch
);
  import bf16dp_pkg::*;

  logic [LANES-1:0][31:0] snap;
  logic                   snap_v;
  logic [LANES-1:0][15:0] rounded;
  logic [LANES-1:0][15:0] q [QDEPTH];
  logic [QPTR_W-1:0]      wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]      count;
  logic                   pop;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rounded[i] = to_bf16(snap[i]);
    end
  end

  assign pop          = out_ch.valid & out_ch.ready;
  assign out_ch.valid = (count != '0);
  assign out_ch.sum_lane = q[rd_ptr];
  assign occupancy    = count + {{(QCNT_W-1){1'b0}}, snap_v};

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= lane_res;
    end
    if (snap_v) begin
      q[wr_ptr] <= rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_v <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      snap_v <= load;
      if (snap_v) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{(QCNT_W-1){1'b0}}, snap_v} - {{(QCNT_W-1){1'b0}}, pop};
    end
  end

endmodule

[sv/bf16_dot_product_lanes.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BF16 dot product lanes
// A result item passes through the product register, the lane snapshot and the result queue.
// Throughput: one input item per cycle while the result queue has room, set by the FP32 accumulate loop.
// Up to four result items queue at the output before input is held off.
// Reset clears every accumulator to +0.0 and empties the result queue.
// ----------------------------------------------------------------------------
module bf16_dot_product_lanes #(
  parameter int LANES = 8
) (
  input logic          clk,
  input logic          rst,
  bf16dp_in_if.sink    in_ch,
  bf16dp_out_if.source out_ch
);
  import bf16dp_pkg::*;

  logic                   take;
  logic                   v1, f1;
  lane_ctrl_t             ctrl;
  logic [LANES-1:0][31:0] lane_res;
  logic [QCNT_W-1:0]      occ;

  assign take     = in_ch.valid & in_ch.ready;
  assign in_ch.ready = ({1'b0, occ} + {{QCNT_W{1'b0}}, v1 & f1}) < (QCNT_W+1)'(QDEPTH);
  assign ctrl.step  = v1;
  assign ctrl.clear = v1 & f1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f1 <= in_ch.final_term;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bf16dp_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .take     (take),
      .act      (in_ch.act_value),
      .wgt      (in_ch.wgt_lane[g]),
      .ctrl     (ctrl),
      .acc_next (lane_res[g])
    );
  end

  bf16dp_merge #(.LANES(LANES)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (v1 & f1),
    .lane_res  (lane_res),
    .occupancy (occ),
    .out_ch    (out_ch)
  );

endmodule

[sv/bf16dp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BF16 dot product checker
// Port-level checks of result timing, stall stability and reset for the dot product lanes.
// ----------------------------------------------------------------------------
module bf16dp_checker #(
  parameter int LANES = 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_final,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [LANES-1:0][15:0] out_sum
);

  logic [3:0] pending;
  logic       in_last;
  logic       out_take;

  assign in_last  = in_valid & in_ready & in_final;
  assign out_take = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 4'd0;
    end else begin
      pending <= pending + {3'b0, in_last} - {3'b0, out_take};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sum))
    else $error("Result item changed while stalled.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("Result item without a last input item.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_last |-> ##3 out_valid)
    else $error("Result item late.");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result queue not empty after reset.");

endmodule

bind bf16_dot_product_lanes bf16dp_checker #(.LANES(LANES)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_final  (in_ch.final_term),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_sum   (out_ch.sum_lane)
);
